>>> hdl/sha512_family_digest_core_macros.svh
// Assertion helpers included by shd_ctrl
`ifndef SHA512_FAMILY_DIGEST_CORE_MACROS_SVH
`define SHA512_FAMILY_DIGEST_CORE_MACROS_SVH

`define SHD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/shd_pkg.sv
`default_nettype none
package shd_pkg;

  localparam int unsigned WordW      = 64;
  localparam int unsigned Rounds     = 80;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned ModeW      = 2;
  localparam logic [ModeW-1:0] ModeReset = 2'd3;
  localparam logic [ModeW-1:0] Mode224   = 2'd0;
  localparam logic [7:0] PadMark = 8'h80;

  typedef struct packed {
    logic [63:0] msg_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic [3:0]  valid_bytes;
    logic        digest_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_FOLD, ST_TAIL, ST_EMIT
  } ctl_state_t;

  // datapath word source for the window write
  typedef enum logic [1:0] {
    SRC_INPUT, SRC_ZERO, SRC_LEN_HI, SRC_LEN_LO
  } word_src_t;

  typedef struct packed {
    logic      push;        // write one word into the block
    word_src_t src;
    logic      pad_fresh;   // write 0x80 word (full last word case)
    logic      start_cmp;   // load working vars from hash
    logic      round;       // do one round
    logic      fold;        // add working vars into hash
    logic      reload;      // IV reload, clear message
    logic      emit_next;   // shift out next digest word
  } dp_cmd_t;

  typedef struct packed {
    logic [4:0] fill;
    logic       round_last;
    logic       emit_last;
  } dp_sts_t;

  function automatic logic [63:0] round_k(input logic [6:0] i);
    logic [63:0] k;
    unique case (i)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [511:0] mode_iv(input logic [1:0] m);
    logic [511:0] v;
    unique case (m)
      2'd0: v = {64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82,
                 64'h679dd514582f9fcf, 64'h0f6d2b697bd44da8, 64'h77e36f7304c48942,
                 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1};
      2'd1: v = {64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151,
                 64'h963877195940eabd, 64'h96283ee2a88effe3, 64'hbe5e1e2553863992,
                 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2};
      2'd2: v = {64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
                 64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
                 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};
      default: v = {64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
                    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    endcase
    return v;
  endfunction

  function automatic logic [2:0] mode_last(input logic [1:0] m);
    logic [2:0] n;
    unique case (m)
      2'd0, 2'd1: n = 3'd3;
      2'd2:       n = 3'd5;
      default:    n = 3'd7;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha512_family_digest_core.sv
// SHA-512 family digest core (SHA-512, SHA-384, SHA-512/256, SHA-512/224).
// Input channel: in_valid/in_stall with in_item (64-bit big-endian word,
// byte count, last flag). Non-last beats count as 8 bytes.
// Output channel: out_valid/out_stall with out_item, one digest word per beat
// (4, 4, 6 or 8 beats per message by digest_mode), digest_end on the last.
// cfg_we/cfg_wdata write digest_mode while idle; it loads the IV and drops
// any partial message.
// Input beats are taken one per cycle while the core is idle; the 16th word of a
// block starts the rounds and a fold on the single shared round unit, and no
// input is taken until they are done.
// After the last beat, padding words are written, then one or two compressions
// run; then digest beats stream out one per cycle while out_stall is low.
// While out_stall is high the current digest beat holds and no input is taken.
// Synchronous reset (rst_n low) selects SHA-512 and clears the message.
`default_nettype none
module sha512_family_digest_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire shd_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output shd_pkg::out_item_t      out_item
);

  shd_pkg::dp_cmd_t cmd;
  shd_pkg::dp_sts_t sts;

  shd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_item.last_word),
    .in_full(in_item.byte_count >= 4'd8), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  shd_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_item(in_item), .cmd(cmd), .sts(sts), .out_item(out_item)
  );

endmodule
`default_nettype wire

>>> hdl/shd_datapath.sv
`default_nettype none
module shd_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire shd_pkg::in_item_t in_item,
  input  wire shd_pkg::dp_cmd_t  cmd,
  output shd_pkg::dp_sts_t       sts,
  output shd_pkg::out_item_t     out_item
);

  localparam logic [511:0] IvReset = shd_pkg::mode_iv(shd_pkg::ModeReset);

  logic [1:0]  mode_r;
  logic [63:0] hash_r [8];
  logic [63:0] v_r [8];
  logic [63:0] win_r [16];
  logic [4:0]  fill_r;
  logic [63:0] bytes_r;
  logic [6:0]  rnd_r;
  logic [2:0]  emit_r;
  logic [511:0] iv;

  logic [3:0]  cnt;
  logic [63:0] keep, marked, push_w, wnew, w, t1, t2;
  logic [63:0] x15, x2, x7, x16;

  assign iv = shd_pkg::mode_iv(cfg_we ? cfg_wdata : mode_r);

  always_comb begin
    cnt = (in_item.byte_count > 4'd8) ? 4'd8 : in_item.byte_count;
    keep = (cnt == 4'd0) ? 64'd0 : ~64'd0 << (7'd64 - {cnt, 3'b000});
    marked = (in_item.msg_word & keep) |
             ({56'd0, shd_pkg::PadMark} << (6'd56 - {cnt[2:0], 3'b000}));
    case (cmd.src)
      shd_pkg::SRC_INPUT:  push_w = (in_item.last_word && cnt != 4'd8) ? marked
                                    : in_item.msg_word;
      shd_pkg::SRC_LEN_HI: push_w = {61'd0, bytes_r[63:61]};
      shd_pkg::SRC_LEN_LO: push_w = {bytes_r[60:0], 3'b000};
      default:             push_w = '0;
    endcase
    if (cmd.pad_fresh) push_w = {shd_pkg::PadMark, 56'd0};
    x16 = win_r[rnd_r[3:0]];
    x15 = win_r[rnd_r[3:0] + 4'd1];
    x7  = win_r[rnd_r[3:0] + 4'd9];
    x2  = win_r[rnd_r[3:0] + 4'd14];
    wnew = x16 + (shd_pkg::rotr(x15, 1) ^ shd_pkg::rotr(x15, 8) ^ (x15 >> 7)) + x7
           + (shd_pkg::rotr(x2, 19) ^ shd_pkg::rotr(x2, 61) ^ (x2 >> 6));
    w = (rnd_r >= 7'd16) ? wnew : x16;
    t1 = v_r[7] + (shd_pkg::rotr(v_r[4], 14) ^ shd_pkg::rotr(v_r[4], 18)
         ^ shd_pkg::rotr(v_r[4], 41)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + shd_pkg::round_k(rnd_r) + w;
    t2 = (shd_pkg::rotr(v_r[0], 28) ^ shd_pkg::rotr(v_r[0], 34) ^ shd_pkg::rotr(v_r[0], 39))
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= shd_pkg::ModeReset;
      fill_r  <= '0;
      bytes_r <= '0;
      rnd_r   <= '0;
      emit_r  <= '0;
      for (int j = 0; j < 8; j++) begin
        hash_r[j] <= IvReset[511-64*j -: 64];
        v_r[j]    <= '0;
      end
    end else if (cfg_we || cmd.reload) begin
      if (cfg_we) mode_r <= cfg_wdata;
      fill_r  <= '0;
      bytes_r <= '0;
      rnd_r   <= '0;
      emit_r  <= '0;
      for (int j = 0; j < 8; j++) hash_r[j] <= iv[511-64*j -: 64];
    end else begin
      if (cmd.push) begin
        win_r[fill_r[3:0]] <= push_w;
        fill_r <= fill_r + 5'd1;
        if (cmd.src == shd_pkg::SRC_INPUT && !cmd.pad_fresh)
          bytes_r <= bytes_r + (in_item.last_word ? {60'd0, cnt} : 64'd8);
      end
      if (cmd.start_cmp) begin
        rnd_r <= '0;
        for (int j = 0; j < 8; j++) v_r[j] <= hash_r[j];
      end
      if (cmd.round) begin
        if (rnd_r >= 7'd16) win_r[rnd_r[3:0]] <= wnew;
        rnd_r <= rnd_r + 7'd1;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
      end
      if (cmd.fold) begin
        fill_r <= '0;
        rnd_r  <= '0;
        for (int j = 0; j < 8; j++) hash_r[j] <= hash_r[j] + v_r[j];
      end
      if (cmd.emit_next) emit_r <= emit_r + 3'd1;
    end
  end

  always_comb begin
    sts.fill       = fill_r;
    sts.round_last = (rnd_r == 7'(shd_pkg::Rounds - 1));
    sts.emit_last  = (emit_r == shd_pkg::mode_last(mode_r));
    out_item.digest_word = hash_r[emit_r];
    out_item.valid_bytes = 4'd8;
    if (mode_r == shd_pkg::Mode224 && emit_r == 3'd3) begin
      out_item.digest_word[31:0] = '0;
      out_item.valid_bytes = 4'd4;
    end
    out_item.word_index = emit_r;
    out_item.digest_end = sts.emit_last;
  end

endmodule
`default_nettype wire

>>> hdl/shd_ctrl.sv
`default_nettype none
`include "sha512_family_digest_core_macros.svh"
module shd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_last,
  input  wire logic             in_full,   // last item holds 8 bytes
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire shd_pkg::dp_sts_t sts,
  output shd_pkg::dp_cmd_t      cmd
);

  shd_pkg::ctl_state_t state_r, state_nxt;
  logic tail_r, tail_nxt;     // message in padding phase
  logic mark_r, mark_nxt;     // 0x80 word still owed
  logic len_r, len_nxt;       // length words placed, digest owed
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shd_pkg::ST_IDLE;
      tail_r  <= 1'b0;
      mark_r  <= 1'b0;
      len_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tail_r  <= tail_nxt;
      mark_r  <= mark_nxt;
      len_r   <= len_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tail_nxt  = tail_r;
    mark_nxt  = mark_r;
    len_nxt   = len_r;
    cmd       = '0;
    cmd.src   = shd_pkg::SRC_INPUT;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    acc       = 1'b0;
    unique case (state_r)
      shd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        acc = in_valid;
        if (acc) begin
          cmd.push = 1'b1;
          if (sts.fill == 5'd15) begin
            cmd.start_cmp = 1'b1;
            state_nxt = shd_pkg::ST_ROUND;
          end else if (in_last) begin
            state_nxt = shd_pkg::ST_TAIL;
          end
          if (in_last) begin
            tail_nxt = 1'b1;
            mark_nxt = in_full;
          end
        end
      end
      shd_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) state_nxt = shd_pkg::ST_FOLD;
      end
      shd_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (tail_r) state_nxt = shd_pkg::ST_TAIL;
        else if (len_r) state_nxt = shd_pkg::ST_EMIT;
        else state_nxt = shd_pkg::ST_IDLE;
      end
      shd_pkg::ST_TAIL: begin
        cmd.push = 1'b1;
        if (mark_r) begin
          cmd.pad_fresh = 1'b1;
          mark_nxt = 1'b0;
        end else if (sts.fill == 5'd14) begin
          cmd.src = shd_pkg::SRC_LEN_HI;
          len_nxt = 1'b1;
        end else if (sts.fill == 5'd15 && len_r) begin
          cmd.src = shd_pkg::SRC_LEN_LO;
        end else begin
          // zero padding word; if the marker landed in word 14 or 15, the length goes in the next block
          cmd.src = shd_pkg::SRC_ZERO;
        end
        if (sts.fill == 5'd15) begin
          cmd.start_cmp = 1'b1;
          state_nxt = shd_pkg::ST_ROUND;
          if (len_r) tail_nxt = 1'b0;
        end
      end
      shd_pkg::ST_EMIT: begin
        cmd.push  = 1'b0;
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_next = 1'b1;
          if (sts.emit_last) begin
            cmd.emit_next = 1'b0;
            cmd.reload = 1'b1;
            len_nxt = 1'b0;
            state_nxt = shd_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = shd_pkg::ST_IDLE;
    endcase
  end

  `SHD_ASSERT_IMPL(a_emit_no_input, clk, rst_n, out_valid, in_stall,
    "input taken while digest is streaming")
  `SHD_ASSERT_NEXT(a_fold_after_rounds, clk, rst_n,
    state_r == shd_pkg::ST_ROUND && sts.round_last, state_r == shd_pkg::ST_FOLD,
    "fold did not follow last round")
  `SHD_ASSERT_IMPL(a_round_block_full, clk, rst_n, cmd.round, sts.fill == 5'd16,
    "round with partial block")

endmodule
`default_nettype wire
